FILE: rtl/core/aes128_ecb_ctr_engine_defines.svh
// Assertion macros shared by the engine
`ifndef AES128_ECB_CTR_ENGINE_DEFINES_SVH
`define AES128_ECB_CTR_ENGINE_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define AES_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/aes_pkg.sv
package aes_pkg;

   localparam int RoundKeyWords = 22;
   localparam int AesRounds     = 10;
   localparam int BlockBits     = 128;
   localparam int CtrBits       = 32;

   localparam logic [1:0] ACT_WRITE_KEY = 2'd0;
   localparam logic [1:0] ACT_ENCRYPT   = 2'd1;
   localparam logic [1:0] ACT_LOAD_CTR  = 2'd2;
   localparam logic [1:0] ACT_KEYSTREAM = 2'd3;

   typedef struct packed {
      logic                 valid;
      logic [BlockBits-1:0] block;
      logic [CtrBits-1:0]   ctr;
   } stage_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte k of a block sits in the most significant bits first
   function automatic logic [BlockBits-1:0] sub_shift(input logic [BlockBits-1:0] blk);
      logic [BlockBits-1:0] t;
      logic [BlockBits-1:0] res;
      int src;
      for (int i = 0; i < 16; i++) begin
         t[BlockBits-1-8*i -: 8] = SBOX[blk[BlockBits-1-8*i -: 8]];
      end
      for (int col = 0; col < 4; col++) begin
         for (int row = 0; row < 4; row++) begin
            src = row + 4 * ((col + row) % 4);
            res[BlockBits-1-8*(row+4*col) -: 8] = t[BlockBits-1-8*src -: 8];
         end
      end
      return res;
   endfunction

   function automatic logic [BlockBits-1:0] mix_columns(input logic [BlockBits-1:0] blk);
      logic [BlockBits-1:0] res;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0  = blk[BlockBits-1-8*(4*c)   -: 8];
         a1  = blk[BlockBits-1-8*(4*c+1) -: 8];
         a2  = blk[BlockBits-1-8*(4*c+2) -: 8];
         a3  = blk[BlockBits-1-8*(4*c+3) -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         res[BlockBits-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         res[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         res[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         res[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/aes_if.sv
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [4:0]  word_index;
   logic [63:0] key_word;
   logic [63:0] block_hi;
   logic [63:0] block_lo;
   logic        iv_short;

   modport source (output valid, action, word_index, key_word, block_hi, block_lo, iv_short,
                   input ready);
   modport sink   (input valid, action, word_index, key_word, block_hi, block_lo, iv_short,
                   output ready);
endinterface

interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_hi;
   logic [63:0] result_lo;
   logic [31:0] counter_used;

   modport source (output valid, result_hi, result_lo, counter_used, input ready);
   modport sink   (input valid, result_hi, result_lo, counter_used, output ready);
endinterface

FILE: rtl/core/aes_cell.sv
module aes_cell import aes_pkg::*; #(
   parameter bit LastRound = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  stage_type            stage_in,
   input  logic [BlockBits-1:0] round_key,
   input  logic [BlockBits-1:0] final_key,
   output stage_type            stage_out
);

   logic                 valid_ff;
   logic [BlockBits-1:0] block_ff, block_in;
   logic [CtrBits-1:0]   ctr_ff;
   logic [BlockBits-1:0] shifted;

   // One round: add key, substitute, shift rows, then mix or final key
   always_comb begin
      shifted = sub_shift(stage_in.block ^ round_key);
      if (LastRound) begin
         block_in = shifted ^ final_key;
      end else begin
         block_in = mix_columns(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   // Hold the payload while the chain is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         block_ff <= block_in;
         ctr_ff   <= stage_in.ctr;
      end
   end

   assign stage_out = '{valid: valid_ff, block: block_ff, ctr: ctr_ff};

endmodule

FILE: rtl/core/aes128_ecb_ctr_engine.sv
// Channel  Dir  Carries
// req_ch   in   action, word_index, key_word, block_hi, block_lo, iv_short
// rsp_ch   out  result_hi, result_lo, counter_used
//
// Ten round cells in a row; a block enters each cycle unless the chain stalls.
// Throughput is one request per cycle, set by the one-round-per-cell chain,
// while no stall holds it; a schedule word write waits until no block is in
// the chain.
// A stalled result freezes the whole chain. Synchronous reset empties the chain
// and zeroes nonce and counter; schedule words are undefined until written.
`include "aes128_ecb_ctr_engine_defines.svh"

module aes128_ecb_ctr_engine import aes_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   aes_req_if.sink      req_ch,
   aes_rsp_if.source    rsp_ch
);

   logic [63:0]        round_key_ff [RoundKeyWords];
   logic [63:0]        nonce_upper_ff;
   logic [31:0]        nonce_lower_ff;
   logic [CtrBits-1:0] block_counter_ff, block_counter_in;

   stage_type          chain [AesRounds+1];
   logic [AesRounds-1:0] busy_vec;
   logic               advance;
   logic               accept;
   logic               is_write;
   logic               is_ks;
   logic [BlockBits-1:0] final_key;

   assign advance  = !chain[AesRounds].valid || rsp_ch.ready;
   assign is_write = (req_ch.action == ACT_WRITE_KEY);
   assign is_ks    = (req_ch.action == ACT_KEYSTREAM);
   assign req_ch.ready = advance && !(is_write && (|busy_vec));
   assign accept   = req_ch.valid && req_ch.ready;

   // Build the block that enters the first cell
   always_comb begin
      chain[0].valid = accept && (req_ch.action == ACT_ENCRYPT || is_ks);
      if (is_ks) begin
         chain[0].block = {nonce_upper_ff, nonce_lower_ff, block_counter_ff};
         chain[0].ctr   = block_counter_ff;
      end else begin
         chain[0].block = {req_ch.block_hi, req_ch.block_lo};
         chain[0].ctr   = '0;
      end
   end

   // Store schedule words
   always_ff @(posedge clock) begin
      if (accept && is_write && req_ch.word_index < 5'(RoundKeyWords)) begin
         round_key_ff[req_ch.word_index] <= req_ch.key_word;
      end
   end

   // Load and advance the counter block
   always_comb begin
      block_counter_in = block_counter_ff;
      if (accept) begin
         unique case (req_ch.action)
            ACT_LOAD_CTR:  block_counter_in = req_ch.iv_short ? '0 : req_ch.block_lo[31:0];
            ACT_KEYSTREAM: block_counter_in = block_counter_ff + 1'b1;
            default:       block_counter_in = block_counter_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonce_upper_ff   <= '0;
         nonce_lower_ff   <= '0;
         block_counter_ff <= '0;
      end else begin
         block_counter_ff <= block_counter_in;
         if (accept && req_ch.action == ACT_LOAD_CTR) begin
            nonce_upper_ff <= req_ch.block_hi;
            nonce_lower_ff <= req_ch.block_lo[63:32];
         end
      end
   end

   assign final_key = {round_key_ff[2*AesRounds], round_key_ff[2*AesRounds+1]};

   // Chain of round cells
   for (genvar r = 0; r < AesRounds; r++) begin : g_round
      aes_cell #(.LastRound(r == AesRounds-1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[r]),
         .round_key ({round_key_ff[2*r], round_key_ff[2*r+1]}),
         .final_key (final_key),
         .stage_out (chain[r+1])
      );
      assign busy_vec[r] = chain[r+1].valid;
   end

   assign rsp_ch.valid        = chain[AesRounds].valid;
   assign rsp_ch.result_hi    = chain[AesRounds].block[127:64];
   assign rsp_ch.result_lo    = chain[AesRounds].block[63:0];
   assign rsp_ch.counter_used = chain[AesRounds].ctr;

   `AES_ASSERT_NOW(a_write_idle, accept && is_write, busy_vec == '0, "schedule write while busy")
   `AES_ASSERT_NEXT(a_ctr_step, accept && is_ks, block_counter_ff == $past(block_counter_ff) + 1'b1, "counter did not advance")
   `AES_ASSERT_NEXT(a_rsp_hold, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid, "result dropped while stalled")

endmodule
